/* rtl/bsesc_pkg.sv */
// ----------------------------------------------------------------------------
// bsesc_pkg
// Shared constants and types for the backslash escape decoder.
// ----------------------------------------------------------------------------
package bsesc_pkg;

  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_SEVEN     = 8'h37;
  localparam logic [7:0] CH_N         = 8'h6E;
  localparam logic [7:0] CH_T         = 8'h74;
  localparam logic [7:0] CH_R         = 8'h72;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CODE_LF      = 8'h0A;
  localparam logic [7:0] CODE_TAB     = 8'h09;
  localparam logic [7:0] CODE_CR      = 8'h0D;
  localparam logic [1:0] MAX_OCTAL_DIGITS = 2'd3;

  // Bundle queue between front and back.
  localparam int QDEPTH = 4;
  localparam int QIDX_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    PH_PLAIN  = 3'b001,
    PH_ESCAPE = 3'b010,
    PH_OCTAL  = 3'b100
  } phase_t;

  // Results of one input item: one or two decoded bytes.
  typedef struct packed {
    logic       two;
    logic [7:0] byte0;
    logic       fin0;
    logic [7:0] byte1;
    logic       fin1;
  } bundle_t;

endpackage

/* rtl/bsesc_front.sv */
// ----------------------------------------------------------------------------
// bsesc_front
// Classifies each input item, tracks escape state and forms its result bundle.
// ----------------------------------------------------------------------------
module bsesc_front
  import bsesc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,       // item accepted this cycle
  input  logic [7:0] in_byte,
  input  logic       in_final,
  output logic       push,
  output bundle_t    bundle
);

  phase_t      phase_r, phase_nxt;
  logic [7:0]  oval_r, oval_nxt;
  logic [1:0]  odig_r, odig_nxt;

  logic        is_oct;
  logic        plain;
  logic [1:0]  n;
  logic [7:0]  oval_sh;
  logic [1:0]  odig_inc;
  logic [7:0]  mapped;

  always_comb begin
    is_oct   = (in_byte >= CH_ZERO) && (in_byte <= CH_SEVEN);
    oval_sh  = {oval_r[4:0], in_byte[2:0]};
    odig_inc = odig_r + 2'd1;
    case (in_byte)
      CH_N:    mapped = CODE_LF;
      CH_T:    mapped = CODE_TAB;
      CH_R:    mapped = CODE_CR;
      default: mapped = in_byte;
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    oval_nxt  = oval_r;
    odig_nxt  = odig_r;
    plain     = 1'b0;
    n         = 2'd0;
    bundle    = '0;

    case (phase_r)
      PH_OCTAL: begin
        if (is_oct) begin
          oval_nxt = oval_sh;
          odig_nxt = odig_inc;
          if (odig_inc >= MAX_OCTAL_DIGITS || in_final) begin
            bundle.byte0 = oval_sh;
            bundle.fin0  = in_final;
            n            = 2'd1;
            phase_nxt    = PH_PLAIN;
          end
        end else begin
          bundle.byte0 = oval_r;
          bundle.fin0  = 1'b0;
          n            = 2'd1;
          phase_nxt    = PH_PLAIN;
          plain        = 1'b1;
        end
      end
      PH_ESCAPE: begin
        if (is_oct) begin
          oval_nxt  = {5'd0, in_byte[2:0]};
          odig_nxt  = 2'd1;
          phase_nxt = PH_OCTAL;
          if (in_final) begin
            bundle.byte0 = {5'd0, in_byte[2:0]};
            bundle.fin0  = 1'b1;
            n            = 2'd1;
          end
        end else begin
          bundle.byte0 = mapped;
          bundle.fin0  = in_final;
          n            = 2'd1;
          phase_nxt    = PH_PLAIN;
        end
      end
      default: begin
        plain = 1'b1;
      end
    endcase

    if (plain) begin
      // Second slot only when an octal run was closed by this byte.
      if (in_byte == CH_BACKSLASH) begin
        phase_nxt = PH_ESCAPE;
        if (in_final) begin
          if (n == 2'd0) begin
            bundle.byte0 = CH_BACKSLASH;
            bundle.fin0  = 1'b1;
          end else begin
            bundle.byte1 = CH_BACKSLASH;
            bundle.fin1  = 1'b1;
          end
          n = n + 2'd1;
        end
      end else begin
        phase_nxt = PH_PLAIN;
        if (n == 2'd0) begin
          bundle.byte0 = in_byte;
          bundle.fin0  = in_final;
        end else begin
          bundle.byte1 = in_byte;
          bundle.fin1  = in_final;
        end
        n = n + 2'd1;
      end
    end

    if (in_final) begin
      phase_nxt = PH_PLAIN;
      oval_nxt  = 8'd0;
      odig_nxt  = 2'd0;
    end

    bundle.two = (n == 2'd2);
    push       = take && (n != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_PLAIN;
      oval_r  <= 8'd0;
      odig_r  <= 2'd0;
    end else if (take) begin
      phase_r <= phase_nxt;
      oval_r  <= oval_nxt;
      odig_r  <= odig_nxt;
    end
  end

endmodule

/* rtl/bsesc_queue.sv */
// ----------------------------------------------------------------------------
// bsesc_queue
// Short register queue of result bundles between front and back.
// ----------------------------------------------------------------------------
module bsesc_queue
  import bsesc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  bundle_t push_data,
  input  logic    pop,
  output logic    not_empty,
  output logic    not_full,
  output bundle_t head
);

  bundle_t             mem_r [QDEPTH];
  logic [QIDX_W-1:0]   wptr_r, rptr_r;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;

  assign not_empty = (cnt_r != '0);
  assign not_full  = (cnt_r != QCNT_W'(QDEPTH));
  assign head      = mem_r[rptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + QCNT_W'(1);
    else if (pop && !push) cnt_nxt = cnt_r - QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + QIDX_W'(1);
      if (pop) rptr_r <= rptr_r + QIDX_W'(1);
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= push_data;
  end

endmodule

/* rtl/bsesc_back.sv */
// ----------------------------------------------------------------------------
// bsesc_back
// Drains result bundles one byte at a time into the output register.
// ----------------------------------------------------------------------------
module bsesc_back
  import bsesc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       head_valid,
  input  bundle_t    head,
  output logic       pop,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,
  output logic       out_tlast
);

  logic       valid_r, valid_nxt;
  logic       half_r, half_nxt;
  logic [7:0] data_r;
  logic       last_r;
  logic       load;

  assign load = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    half_nxt  = half_r;
    pop       = 1'b0;
    if (load) begin
      valid_nxt = head_valid;
      if (head_valid) begin
        // Hold the bundle for its second byte, else retire it.
        if (!half_r && head.two) begin
          half_nxt = 1'b1;
        end else begin
          half_nxt = 1'b0;
          pop      = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      half_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      half_r  <= half_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      data_r <= half_r ? head.byte1 : head.byte0;
      last_r <= half_r ? head.fin1 : head.fin0;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tlast  = last_r;

endmodule

/* rtl/backslash_escape_decoder.sv */
// ----------------------------------------------------------------------------
// backslash_escape_decoder
// Decodes a backslash-escaped byte stream (octal, \n, \t, \r) into raw bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream in_*: one escaped byte per item in in_tdata, in_tlast marks
//   the final byte of a string. Output stream out_*: one decoded byte per
//   item, out_tlast marks the last decoded byte of the string.
//   The front decodes an item in the cycle it is accepted and writes its one
//   or two result bytes as a bundle into a four-entry queue; items that give
//   no result leave nothing. The back drains the queue through an output
//   register, one byte per cycle while out_tready stays high.
//   Timing: on an idle pipe a result shows on out_* right after the clock
//   edge that follows the accepting edge; the second byte of a two-byte
//   item goes out after the first, from the same queue entry.
//   Throughput: one item per cycle while each gives at most one byte and
//   out_tready stays high; a two-byte item is limited by the single output port.
//   in_tready drops only when the queue holds four bundles.
//   Reset (rst_n low, synchronous) empties the queue, clears out_tvalid and
//   returns the decoder to plain text. A stalled receiver holds out_* steady
//   and fills the queue before backpressure reaches the input.
// ----------------------------------------------------------------------------
module backslash_escape_decoder
  import bsesc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,   // in_final
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast   // out_final
);

  logic    take;
  logic    push;
  bundle_t push_data;
  logic    pop;
  logic    not_empty;
  logic    not_full;
  bundle_t head;

  assign in_tready = not_full;
  assign take      = in_tvalid && not_full;

  bsesc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (take),
    .in_byte  (in_tdata),
    .in_final (in_tlast),
    .push     (push),
    .bundle   (push_data)
  );

  bsesc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .not_empty (not_empty),
    .not_full  (not_full),
    .head      (head)
  );

  bsesc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (not_empty),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

/* rtl/bsesc_checker.sv */
// ----------------------------------------------------------------------------
// bsesc_checker
// Port-level checks for the backslash escape decoder, bound to the top level.
// ----------------------------------------------------------------------------
module bsesc_checker
  import bsesc_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic [7:0] in_tdata,
  input logic       in_tlast,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  // Reset leaves the queue empty and the output idle.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> (in_tready && !out_tvalid))
    else $error("reset did not clear the decoder");

  // An idle output means the queue is nearly empty, so the input is open.
  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled while output idle");

  // Stalled output item holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tlast)))
    else $error("stalled output item changed");

  // An accepted final byte other than a backslash on an empty pipe shows up
  // on the output once the queue and then the output register have taken it.
  a_plain_through: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_tvalid && in_tvalid && in_tready && in_tlast && $past(in_tlast)
     && $past(rst_n) && $past(in_tvalid) && $past(in_tready) && $past(!out_tvalid)
     && in_tdata != CH_BACKSLASH && $past(in_tdata) != CH_BACKSLASH) |=> out_tvalid)
    else $error("plain byte did not reach the output");

endmodule

bind backslash_escape_decoder bsesc_checker u_bsesc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

/* tb/backslash_escape_decoder_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// backslash_escape_decoder_tb
// Self-checking bench for the backslash escape decoder. Escaped strings are
// streamed in with random bursts and gaps. A behavioral decoder predicts the
// decoded bytes, and each output item is checked in order. The receiver
// stalls on changing patterns, including one long hold-off.
// ----------------------------------------------------------------------------
module backslash_escape_decoder_tb;
  import bsesc_pkg::*;

  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 1050;
  localparam int FLOOD_ITEMS  = 80;

  typedef struct {
    logic [7:0] value;
    logic       fin;
  } decoded_t;

  typedef enum {RX_STREAM, RX_HALF, RX_SPARSE, RX_TOGGLE} rx_mode_t;

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;    // [7:0] in_byte
  logic       in_tlast;    // in_final
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;   // [7:0] out_byte
  logic       out_tlast;   // out_final

  // Predictor state
  phase_t     dec_phase;
  logic [7:0] dec_value;
  logic [1:0] dec_digits;

  decoded_t   decoded_q[$];
  logic [7:0] str_buf[$];

  int         error_count;
  int         items_sent;
  int         strings_sent;
  int         bytes_checked;
  int         burst_left;
  bit         hold_req;
  int         hold_left;
  int         stretch_left;
  rx_mode_t   rx_mode;

  backslash_escape_decoder i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("** backslash_escape_decoder: FAILED **");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  function automatic bit is_octal_digit(input logic [7:0] b);
    return b >= CH_ZERO && b <= CH_SEVEN;
  endfunction

  task automatic push_decoded(input logic [7:0] value, input logic fin);
    decoded_t d;
    d.value = value;
    d.fin   = fin;
    decoded_q.push_back(d);
  endtask

  task automatic predict_decode(input logic [7:0] b, input logic fin);
    bit         as_plain;
    logic [7:0] mapped;
    as_plain = 1'b0;
    case (dec_phase)
      PH_OCTAL: begin
        if (is_octal_digit(b)) begin
          dec_value  = {dec_value[4:0], 3'b000} + (b - CH_ZERO);
          dec_digits = dec_digits + 2'd1;
          if (dec_digits >= MAX_OCTAL_DIGITS || fin) begin
            push_decoded(dec_value, fin);
            dec_phase = PH_PLAIN;
          end
        end else begin
          // close the run, then treat the byte as plain text
          push_decoded(dec_value, 1'b0);
          dec_phase = PH_PLAIN;
          as_plain  = 1'b1;
        end
      end
      PH_ESCAPE: begin
        if (is_octal_digit(b)) begin
          dec_value  = b - CH_ZERO;
          dec_digits = 2'd1;
          dec_phase  = PH_OCTAL;
          if (fin) push_decoded(dec_value, 1'b1);
        end else begin
          case (b)
            CH_N:    mapped = CODE_LF;
            CH_T:    mapped = CODE_TAB;
            CH_R:    mapped = CODE_CR;
            default: mapped = b;
          endcase
          push_decoded(mapped, fin);
          dec_phase = PH_PLAIN;
        end
      end
      default: as_plain = 1'b1;
    endcase

    if (as_plain) begin
      if (b == CH_BACKSLASH) begin
        dec_phase = PH_ESCAPE;
        if (fin) push_decoded(CH_BACKSLASH, 1'b1);
      end else begin
        dec_phase = PH_PLAIN;
        push_decoded(b, fin);
      end
    end

    if (fin) begin
      dec_phase  = PH_PLAIN;
      dec_value  = 8'h00;
      dec_digits = 2'd0;
    end
  endtask

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------
  task automatic send_item(input logic [7:0] b, input logic fin);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 4);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= fin;
    do @(posedge clk); while (!in_tready);
    burst_left--;
    items_sent++;
    predict_decode(b, fin);
  endtask

  // Send the string in str_buf, final mark on its last byte.
  task automatic send_string();
    foreach (str_buf[i]) send_item(str_buf[i], i == str_buf.size() - 1);
    strings_sent++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
  endtask

  task automatic build_random_string();
    int ntok;
    int kind;
    int ndig;
    str_buf.delete();
    ntok = $urandom_range(1, 6);
    repeat (ntok) begin
      kind = $urandom_range(0, 11);
      case (kind)
        0, 1, 2: str_buf.push_back(8'($urandom_range(0, 255)));
        3: begin
          str_buf.push_back(CH_BACKSLASH);
          case ($urandom_range(0, 2))
            0:       str_buf.push_back(CH_N);
            1:       str_buf.push_back(CH_T);
            default: str_buf.push_back(CH_R);
          endcase
        end
        4: begin
          str_buf.push_back(CH_BACKSLASH);
          str_buf.push_back(8'($urandom_range(0, 255)));
        end
        5, 6, 7, 8: begin
          str_buf.push_back(CH_BACKSLASH);
          ndig = $urandom_range(1, 3);
          repeat (ndig) str_buf.push_back(CH_ZERO + 8'($urandom_range(0, 7)));
        end
        9: begin
          str_buf.push_back(CH_BACKSLASH);
          str_buf.push_back(CH_BACKSLASH);
        end
        10: str_buf.push_back(CH_ZERO + 8'($urandom_range(0, 7)));
        // dangling backslash: the next token or the end decides
        default: str_buf.push_back(CH_BACKSLASH);
      endcase
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver and checker
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    decoded_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (decoded_q.size() == 0) begin
        $display("%0t: unexpected item: expected none, got byte %02h last %b",
                 $time, out_tdata, out_tlast);
        error_count++;
      end else begin
        want = decoded_q.pop_front();
        bytes_checked++;
        if (out_tdata !== want.value) begin
          $display("%0t: out_tdata mismatch: expected %02h, got %02h",
                   $time, want.value, out_tdata);
          error_count++;
        end
        if (out_tlast !== want.fin) begin
          $display("%0t: out_tlast mismatch: expected %b, got %b",
                   $time, want.fin, out_tlast);
          error_count++;
        end
      end
    end

    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (stretch_left == 0) begin
      rx_mode      = rx_mode_t'($urandom_range(0, 3));
      stretch_left = $urandom_range(20, 80);
    end else begin
      stretch_left--;
    end

    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_STREAM: out_tready <= 1'b1;
        RX_HALF:   out_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_tready <= ($urandom_range(0, 3) == 0);
        default:   out_tready <= ~out_tready;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_control_escapes();
    // control codes, escaped zero, plain 0xFF, lone trailing backslash
    str_buf = '{CH_BACKSLASH, CH_N, CH_BACKSLASH, CH_T, CH_BACKSLASH, CH_R,
                CH_BACKSLASH, 8'h00, 8'hFF, CH_BACKSLASH};
    send_string();
  endtask

  task automatic test_octal_runs();
    // 777 overflows to 0xFF; '8' and a backslash end runs; a non-octal
    // final byte follows an open run
    str_buf = '{CH_BACKSLASH, CH_SEVEN, CH_SEVEN, CH_SEVEN,
                CH_BACKSLASH, 8'h31, 8'h38,
                CH_BACKSLASH, CH_ZERO, CH_BACKSLASH, 8'h71,
                CH_BACKSLASH, 8'h32, 8'h5A};
    send_string();
  endtask

  task automatic test_final_first_digit();
    str_buf = '{CH_BACKSLASH, 8'h35};
    send_string();
  endtask

  task automatic test_receiver_holdoff();
    int start;
    start    = items_sent;
    hold_req = 1'b1;
    while (items_sent - start < FLOOD_ITEMS) begin
      build_random_string();
      send_string();
    end
  endtask

  task automatic test_drain_pause();
    wait_drained();
  endtask

  task automatic test_random_strings(input int target);
    int start;
    start = items_sent;
    while (items_sent - start < target) begin
      build_random_string();
      send_string();
      if ($urandom_range(0, 40) == 0) wait_drained();
    end
  endtask

  initial begin
    rst_n        <= 1'b0;
    in_tvalid    <= 1'b0;
    in_tdata     <= 8'h00;
    in_tlast     <= 1'b0;
    out_tready   <= 1'b0;
    dec_phase     = PH_PLAIN;
    dec_value     = 8'h00;
    dec_digits    = 2'd0;
    error_count   = 0;
    items_sent    = 0;
    strings_sent  = 0;
    bytes_checked = 0;
    burst_left    = 0;
    hold_req      = 1'b0;
    hold_left     = 0;
    stretch_left  = 0;
    rx_mode       = RX_STREAM;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_control_escapes();
    test_octal_runs();
    test_final_first_digit();
    test_receiver_holdoff();
    test_drain_pause();
    test_random_strings(RANDOM_ITEMS);

    wait_drained();
    repeat (8) @(posedge clk);

    $display("Summary: %0d escaped bytes in %0d strings, %0d decoded bytes checked,",
             items_sent, strings_sent, bytes_checked);
    $display("  with escapes, octal runs, output hold-off and drain pauses.");
    if (error_count == 0) begin
      $display("** backslash_escape_decoder: PASSED **");
    end else begin
      $display("** backslash_escape_decoder: FAILED **");
    end
    $finish;
  end

endmodule
